>>> rtl/smpd_pkg.sv
// Shared types and constants for the serial mouse packet decoder.
package smpd_pkg;

  localparam logic [7:0] IdByteM       = 8'h4D;
  localparam logic [7:0] IdByte3       = 8'h33;
  localparam logic [7:0] MiddlePattern = 8'h40;
  localparam logic [6:0] LimitReset    = 7'd10;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } pos_e;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } packet_t;

endpackage

>>> rtl/serial_mouse_packet_decoder.sv
// Top level of the serial mouse packet decoder.
// Takes one received byte per clock while rx_stall_o is low and emits one report
// (buttons, dx, dy) per three-byte packet; 'M' and '3' bytes restart packet
// grouping. The edge that accepts a packet's third byte pushes the packet into
// the two-entry queue; a later edge pops it into the decode register once that
// register is empty or its report is not stalled. rx_stall_o rises only when
// the queue is full, which happens only under sustained report stall.
// motion_limit resets to 10 and is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce.
module serial_mouse_packet_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              rpt_valid_o,
  input  logic              rpt_stall_i,
  output logic [2:0]        buttons_o,
  output logic signed [7:0] dx_o,
  output logic signed [7:0] dy_o
);

  logic              q_push, q_full, q_pop, q_empty;
  smpd_pkg::packet_t push_word, pop_word;

  smpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  smpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_word_o  (pop_word)
  );

  smpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .q_word_i    (pop_word),
    .q_pop_o     (q_pop),
    .rpt_valid_o (rpt_valid_o),
    .rpt_stall_i (rpt_stall_i),
    .buttons_o   (buttons_o),
    .dx_o        (dx_o),
    .dy_o        (dy_o)
  );

endmodule

>>> rtl/smpd_front.sv
// Byte grouping front end: collects three bytes into a packet and queues it.
module smpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_stall_o,
  input  logic [7:0]       rx_byte_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output smpd_pkg::packet_t q_word_o
);

  smpd_pkg::pos_e pos_q, pos_d;
  logic [7:0]     first_q, first_d;
  logic [7:0]     second_q, second_d;
  logic           accept;
  logic           is_id;

  assign rx_stall_o = q_full_i;
  assign accept     = rx_valid_i && !q_full_i;
  assign is_id      = (rx_byte_i == smpd_pkg::IdByteM) || (rx_byte_i == smpd_pkg::IdByte3);

  always_comb begin
    pos_d    = pos_q;
    first_d  = first_q;
    second_d = second_q;
    q_push_o = 1'b0;
    if (accept) begin
      if (is_id) begin
        pos_d = smpd_pkg::POS_FIRST;
      end else begin
        case (pos_q)
          smpd_pkg::POS_SECOND: begin
            second_d = rx_byte_i;
            pos_d    = smpd_pkg::POS_THIRD;
          end
          smpd_pkg::POS_THIRD: begin
            q_push_o = 1'b1;
            pos_d    = smpd_pkg::POS_FIRST;
          end
          default: begin
            first_d = rx_byte_i;
            pos_d   = smpd_pkg::POS_SECOND;
          end
        endcase
      end
    end
  end

  assign q_word_o = '{b0: first_q, b1: second_q, b2: rx_byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= smpd_pkg::POS_FIRST;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

>>> rtl/smpd_queue.sv
// Two-entry packet queue between the front end and the decode stage.
module smpd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  smpd_pkg::packet_t push_word_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output smpd_pkg::packet_t pop_word_o
);

  smpd_pkg::packet_t mem_q [smpd_pkg::QueueDepth];
  logic [smpd_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [smpd_pkg::QueueCntW-1:0] count_q, count_d;

  assign full_o     = (count_q == smpd_pkg::QueueCntW'(smpd_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_word_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[smpd_pkg::QueuePtrW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/smpd_back.sv
// Decode stage: button logic, motion assembly and clamping, report register.
module smpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              q_empty_i,
  input  smpd_pkg::packet_t q_word_i,
  output logic              q_pop_o,
  output logic              rpt_valid_o,
  input  logic              rpt_stall_i,
  output logic [2:0]        buttons_o,
  output logic signed [7:0] dx_o,
  output logic signed [7:0] dy_o
);

  logic [6:0]        limit_q;
  logic              valid_q;
  logic [2:0]        buttons_q, buttons_d;
  logic [2:0]        prev_q;
  logic signed [7:0] dx_q, dx_d, dy_q, dy_d;
  logic [7:0]        xr, yr;
  logic signed [8:0] lim_pos, lim_neg;

  assign q_pop_o = !q_empty_i && (!valid_q || !rpt_stall_i);

  assign xr = {q_word_i.b0[1:0], q_word_i.b1[5:0]};
  assign yr = {q_word_i.b0[3:2], q_word_i.b2[5:0]};
  assign lim_pos = $signed({2'b00, limit_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    logic signed [8:0] vx, vy;
    vx = 9'($signed(xr));
    vy = 9'($signed(yr));
    if (vx > lim_pos)      dx_d = lim_pos[7:0];
    else if (vx < lim_neg) dx_d = lim_neg[7:0];
    else                   dx_d = vx[7:0];
    if (vy > lim_pos)      dy_d = lim_pos[7:0];
    else if (vy < lim_neg) dy_d = lim_neg[7:0];
    else                   dy_d = vy[7:0];
  end

  always_comb begin
    // middle press is only reported from an all-released state
    if (q_word_i.b0 == smpd_pkg::MiddlePattern && prev_q == '0 &&
        q_word_i.b1 == '0 && q_word_i.b2 == '0) begin
      buttons_d = 3'b100;
    end else begin
      buttons_d = {1'b0, q_word_i.b0[4], q_word_i.b0[5]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      buttons_q <= buttons_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= smpd_pkg::LimitReset;
      valid_q <= 1'b0;
      prev_q  <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (q_pop_o) begin
        valid_q <= 1'b1;
        prev_q  <= buttons_d;
      end else if (!rpt_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign rpt_valid_o = valid_q;
  assign buttons_o   = buttons_q;
  assign dx_o        = dx_q;
  assign dy_o        = dy_q;

`ifndef SYNTHESIS
  a_middle_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && buttons_q[2]) |-> (buttons_q[1:0] == 2'b00))
    else $error("middle reported with left or right");
  a_dx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((9'(dx_q) <= lim_pos) && (9'(dx_q) >= lim_neg)))
    else $error("dx outside motion limit");
  a_dy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((9'(dy_q) <= lim_pos) && (9'(dy_q) >= lim_neg)))
    else $error("dy outside motion limit");
`endif

endmodule
